// ===== src/htw_pkg.sv =====
// Shared constants, types and bucket-selection functions for the timing wheel.
// Used by hierarchical_timing_wheel (htw_ram does not import it); depends on nothing else.
package htw_pkg;

  localparam int NEAR_BITS   = 8;
  localparam int LEVEL_BITS  = 6;
  localparam int NUM_LEVELS  = 4;
  localparam int POOL_SIZE   = 64;
  localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
  localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
  localparam int NUM_BUCKETS = NEAR_SLOTS + NUM_LEVELS * LEVEL_SLOTS;

  localparam int NODE_W = 7;                     // node number incl. the empty marker
  localparam int NODE_AW = $clog2(POOL_SIZE);
  localparam int BKT_AW = $clog2(NUM_BUCKETS);
  localparam int BKT_DW = 2 * NODE_W;            // {head, tail}
  localparam int TIME_W = 32;
  localparam int ID_W = 64;

  localparam logic [NODE_W-1:0] NIL = 7'd127;
  localparam logic [NODE_W-1:0] POOL_N = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POLL   = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_INSERTED = 2'd0,
    K_FULL     = 2'd1,
    K_EXPIRED  = 2'd2,
    K_NOTHING  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_WR,
    S_PL_RD,
    S_PL_UPD,
    S_PL_LINK,
    S_TICK,
    S_CAS_RD,
    S_CAS_CLR,
    S_CAS_LOOP,
    S_CAS_GOT,
    S_DR_RD,
    S_DR_CLR,
    S_DR_LOOP,
    S_DR_EMIT
  } state_t;

  // Bucket for an expiry: near slot when the upper bits match the time,
  // otherwise the lowest cascade level whose widened mask matches, or the top level if none does.
  function automatic logic [BKT_AW-1:0] bucket_of(input logic [TIME_W-1:0] e,
                                                  input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] m;
    logic [TIME_W-1:0] sh;
    logic              found;
    int                lvl;
    lvl = NUM_LEVELS - 1;
    found = 1'b0;
    m = TIME_W'((64'd1 << NEAR_BITS) - 64'd1);
    if ((e | m) == (t | m)) begin
      bucket_of = BKT_AW'(e & m);
    end else begin
      for (int i = 0; i < NUM_LEVELS - 1; i++) begin
        m = TIME_W'((64'd1 << (NEAR_BITS + LEVEL_BITS * (i + 1))) - 64'd1);
        if (!found && ((e | m) == (t | m))) begin
          found = 1'b1;
          lvl = i;
        end
      end
      sh = (e >> (NEAR_BITS + LEVEL_BITS * lvl)) & TIME_W'(LEVEL_SLOTS - 1);
      bucket_of = BKT_AW'(NEAR_SLOTS + lvl * LEVEL_SLOTS) + BKT_AW'(sh);
    end
  endfunction

  // Cascade bucket chosen when the time advances to t (bit BKT_AW set = cascade).
  function automatic logic [BKT_AW:0] cascade_of(input logic [TIME_W-1:0] t);
    logic              active;
    logic [TIME_W-1:0] m;
    logic [TIME_W-1:0] idx;
    logic [BKT_AW:0]   r;
    r = '0;
    active = 1'b1;
    if (t == '0) begin
      r = {1'b1, BKT_AW'(NEAR_SLOTS + (NUM_LEVELS - 1) * LEVEL_SLOTS)};
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        m = TIME_W'((64'd1 << (NEAR_BITS + LEVEL_BITS * i)) - 64'd1);
        idx = (t >> (NEAR_BITS + LEVEL_BITS * i)) & TIME_W'(LEVEL_SLOTS - 1);
        if (active) begin
          if ((t & m) != '0) begin
            active = 1'b0;
          end else if (idx != '0) begin
            active = 1'b0;
            r = {1'b1, BKT_AW'(NEAR_SLOTS + i * LEVEL_SLOTS) + BKT_AW'(idx)};
          end
        end
      end
    end
    cascade_of = r;
  endfunction

endpackage

// ===== src/htw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hierarchical_timing_wheel.sv =====
// Hierarchical timing wheel: near wheel of 256 slots, four cascade wheels of 64.
// Insert links a node at its bucket's tail; poll drains the current near slot, one
// result per expired id; tick advances the time, on a rollover re-files the nodes of
// a cascade bucket, then drains. One item at a time; the shared bucket and node RAM
// ports set the pace. After rst_n a clearing pass (busy high) empties all 512 bucket
// entries and rebuilds the free chain; the receiver cannot stall the result strobe.
module hierarchical_timing_wheel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [htw_pkg::ID_W-1:0]   in_timer_id,
  input  logic [htw_pkg::TIME_W-1:0] in_delay_ticks,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [htw_pkg::ID_W-1:0]   out_expired_id,
  output logic                      out_last
);
  import htw_pkg::*;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] ct_r, ct_nxt;
  logic [NODE_W-1:0] free_head_r, free_head_nxt;
  logic [NODE_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] next_r, next_nxt;
  logic [NODE_W-1:0] tail_r, tail_nxt;
  logic [NODE_W-1:0] cnt_r, cnt_nxt;       // drained ids or cascade guard
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [BKT_AW-1:0] bkt_r, bkt_nxt;
  logic [BKT_AW-1:0] clr_r, clr_nxt;
  logic              mode_cas_r, mode_cas_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM ports
  logic              bk_we;
  logic [BKT_AW-1:0] bk_waddr, bk_raddr;
  logic [BKT_DW-1:0] bk_wdata, bk_rdata;
  logic              ln_we;
  logic [NODE_AW-1:0] ln_waddr, nd_raddr;
  logic [NODE_W-1:0] ln_wdata, ln_rdata;
  logic              nd_we;
  logic [NODE_AW-1:0] nd_waddr;
  logic [TIME_W-1:0] ex_wdata, ex_rdata;
  logic [ID_W-1:0]   id_rdata;

  logic [NODE_W-1:0] rd_head, rd_tail;
  logic              accept;
  logic              pool_empty;
  logic              node_ok;
  logic              cnt_ok;
  logic              clr_done;
  logic [BKT_AW:0]   cas_sel;

  assign rd_head    = bk_rdata[BKT_DW-1:NODE_W];
  assign rd_tail    = bk_rdata[NODE_W-1:0];
  assign accept     = start && (state_r == S_IDLE);
  assign pool_empty = (free_cnt_r == '0) || (free_head_r >= POOL_N);
  assign node_ok    = node_r < POOL_N;
  assign cnt_ok     = cnt_r < POOL_N;
  assign clr_done   = clr_r == BKT_AW'(NUM_BUCKETS - 1);
  assign cas_sel    = cascade_of(ct_r);
  assign busy       = state_r != S_IDLE;

  htw_ram #(.WIDTH(BKT_DW), .DEPTH(NUM_BUCKETS)) u_bucket (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata)
  );
  htw_ram #(.WIDTH(NODE_W), .DEPTH(POOL_SIZE)) u_link (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(nd_raddr), .rdata(ln_rdata)
  );
  htw_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SIZE)) u_expiry (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(ex_wdata),
    .raddr(nd_raddr), .rdata(ex_rdata)
  );
  htw_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_ident (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(in_timer_id),
    .raddr(nd_raddr), .rdata(id_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (opcode_t'(in_opcode))
            OP_INSERT: if (!pool_empty) state_nxt = S_INS_WR;
            OP_POLL:   state_nxt = S_DR_RD;
            OP_TICK:   state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_WR:   state_nxt = S_PL_RD;
      S_PL_RD:    state_nxt = S_PL_UPD;
      S_PL_UPD: begin
        if (rd_head != NIL && rd_tail < POOL_N) begin
          state_nxt = S_PL_LINK;
        end else begin
          state_nxt = mode_cas_r ? S_CAS_LOOP : S_IDLE;
        end
      end
      S_PL_LINK:  state_nxt = mode_cas_r ? S_CAS_LOOP : S_IDLE;
      S_TICK:     state_nxt = cas_sel[BKT_AW] ? S_CAS_RD : S_DR_RD;
      S_CAS_RD:   state_nxt = S_CAS_CLR;
      S_CAS_CLR:  state_nxt = S_CAS_LOOP;
      S_CAS_LOOP: state_nxt = (node_ok && cnt_ok) ? S_CAS_GOT : S_DR_RD;
      S_CAS_GOT:  state_nxt = S_PL_RD;
      S_DR_RD:    state_nxt = S_DR_CLR;
      S_DR_CLR:   state_nxt = S_DR_LOOP;
      S_DR_LOOP:  state_nxt = (node_ok && cnt_ok) ? S_DR_EMIT : S_IDLE;
      S_DR_EMIT:  state_nxt = S_DR_LOOP;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result strobe.
  always_comb begin
    ct_nxt        = ct_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    node_nxt      = node_r;
    next_nxt      = next_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    bkt_nxt       = bkt_r;
    clr_nxt       = clr_r;
    mode_cas_nxt  = mode_cas_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = K_NOTHING;
    out_id_nxt    = '0;
    out_last_nxt  = 1'b0;
    bk_we    = 1'b0;
    bk_waddr = bkt_r;
    bk_wdata = {NIL, NIL};
    bk_raddr = bkt_r;
    ln_we    = 1'b0;
    ln_waddr = node_r[NODE_AW-1:0];
    ln_wdata = NIL;
    nd_we    = 1'b0;
    nd_waddr = free_head_r[NODE_AW-1:0];
    nd_raddr = node_r[NODE_AW-1:0];
    ex_wdata = ct_r + in_delay_ticks;

    unique case (state_r)
      S_CLEAR: begin
        // Empty every bucket and rebuild the free chain node by node.
        bk_we    = 1'b1;
        bk_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r < BKT_AW'(POOL_SIZE)) begin
          ln_we    = 1'b1;
          ln_waddr = clr_r[NODE_AW-1:0];
          ln_wdata = (clr_r == BKT_AW'(POOL_SIZE - 1)) ? NIL : NODE_W'(clr_r + 1'b1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_opcode))
            OP_INSERT: begin
              if (pool_empty) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = K_FULL;
                out_last_nxt  = 1'b1;
              end else begin
                nd_we        = 1'b1;
                nd_raddr     = free_head_r[NODE_AW-1:0];
                node_nxt     = free_head_r;
                exp_nxt      = ex_wdata;
                mode_cas_nxt = 1'b0;
              end
            end
            OP_TICK: begin
              ct_nxt = ct_r + 1'b1;
            end
            OP_POLL: begin
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = K_NOTHING;
              out_last_nxt  = 1'b1;
            end
          endcase
        end
      end
      S_INS_WR: begin
        free_head_nxt = ln_rdata;
        free_cnt_nxt  = free_cnt_r - 1'b1;
      end
      S_PL_RD: begin
        bkt_nxt  = bucket_of(exp_r, ct_r);
        bk_raddr = bkt_nxt;
      end
      S_PL_UPD: begin
        ln_we = 1'b1;
        bk_we = 1'b1;
        if (rd_head != NIL && rd_tail < POOL_N) begin
          bk_wdata = {rd_head, node_r};
          tail_nxt = rd_tail;
        end else begin
          bk_wdata = {node_r, node_r};
          if (mode_cas_r) begin
            node_nxt = next_r;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_INSERTED;
            out_last_nxt  = 1'b1;
          end
        end
      end
      S_PL_LINK: begin
        ln_we    = 1'b1;
        ln_waddr = tail_r[NODE_AW-1:0];
        ln_wdata = node_r;
        if (mode_cas_r) begin
          node_nxt = next_r;
        end else begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_INSERTED;
          out_last_nxt  = 1'b1;
        end
      end
      S_TICK: begin
        bkt_nxt      = cas_sel[BKT_AW-1:0];
        mode_cas_nxt = 1'b1;
      end
      S_CAS_RD: begin
        bk_raddr = bkt_r;
      end
      S_CAS_CLR: begin
        bk_we    = 1'b1;
        node_nxt = rd_head;
        cnt_nxt  = '0;
      end
      S_CAS_LOOP: begin
      end
      S_CAS_GOT: begin
        next_nxt = ln_rdata;
        exp_nxt  = ex_rdata;
        cnt_nxt  = cnt_r + 1'b1;
      end
      S_DR_RD: begin
        bkt_nxt  = {1'b0, ct_r[NEAR_BITS-1:0]};
        bk_raddr = bkt_nxt;
      end
      S_DR_CLR: begin
        bk_we    = 1'b1;
        node_nxt = rd_head;
        cnt_nxt  = '0;
      end
      S_DR_LOOP: begin
        if (!(node_ok && cnt_ok) && cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_NOTHING;
          out_last_nxt  = 1'b1;
        end
      end
      S_DR_EMIT: begin
        // Hand the id out and push the node back on the free list.
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_EXPIRED;
        out_id_nxt    = id_rdata;
        out_last_nxt  = (ln_rdata >= POOL_N) || (cnt_r == POOL_N - 1'b1);
        ln_we         = 1'b1;
        ln_wdata      = free_head_r;
        free_head_nxt = node_r;
        free_cnt_nxt  = free_cnt_r + 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        node_nxt      = ln_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ct_r        <= '0;
      free_head_r <= '0;
      free_cnt_r  <= POOL_N;
      clr_r       <= '0;
      mode_cas_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ct_r        <= ct_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      clr_r       <= clr_nxt;
      mode_cas_r  <= mode_cas_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    next_r     <= next_nxt;
    tail_r     <= tail_nxt;
    cnt_r      <= cnt_nxt;
    exp_r      <= exp_nxt;
    bkt_r      <= bkt_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

endmodule
